[src/sae_pkg.sv]
// Shared types, widths and the prototype table of the structural alphabet encoder.
// Used by the front end, queue, back end and top level; depends on nothing.
package sae_pkg;

	localparam int COORD_W   = 24;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int IDX_W     = 16;
	localparam int LET_W     = 5;
	localparam int NUM_LET   = 27;
	localparam logic [IDX_W-1:0] MAX_COUNT = '1;

	// shared multiply unit: 52-bit magnitudes in 26-bit halves
	localparam int MAG_W     = 52;
	localparam int HALF_W    = MAG_W / 2;
	localparam int PROD_W    = 2 * MAG_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int NUM_OPS   = 21;

	localparam int N_W       = 51;
	localparam int DOT_W     = 78;
	localparam int NN_W      = 100;
	localparam int SS_W      = 51;

	// square root unit
	localparam int RAD_W     = 104;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int REM_W     = ROOT_W + 4;
	localparam int SQ_ITERS  = RAD_W / 2;

	// divider
	localparam int DREM_W    = ROOT_W + 1;
	localparam int Q_W       = 28;
	localparam int D4_W      = Q_W + 1;
	localparam int DESC_W    = 26;

	// scoring
	localparam int PRO_W     = 13;
	localparam int E_W       = 31;
	localparam int SC_W      = 60;

	typedef struct packed {
		logic                          ok;
		logic [IDX_W-1:0]              idx;
		logic [2:0][DIFF_W-1:0]        u;
		logic [2:0][DIFF_W-1:0]        v;
		logic [2:0][DIFF_W-1:0]        w;
		logic [2:0][DIFF_W-1:0]        bd;
	} sae_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} sae_qstat_t;

	localparam logic signed [PRO_W-1:0] PROTO [NUM_LET][4] = '{
		'{13'sd1380, 13'sd1303, 13'sd1377, 13'sd748},
		'{13'sd1390, 13'sd1303, 13'sd1388, 13'sd753},
		'{13'sd1385, 13'sd1339, 13'sd1436, 13'sd732},
		'{13'sd1439, 13'sd1344, 13'sd1388, 13'sd735},
		'{13'sd1431, 13'sd1405, 13'sd1480, 13'sd660},
		'{13'sd1382, 13'sd1428, 13'sd1388, 13'sd868},
		'{13'sd1480, 13'sd1454, 13'sd1554, 13'sd374},
		'{13'sd1421, 13'sd1981, 13'sd1434, -13'sd847},
		'{13'sd1434, 13'sd1718, 13'sd1408, 13'sd945},
		'{13'sd1457, 13'sd2071, 13'sd1452, 13'sd791},
		'{13'sd1449, 13'sd2291, 13'sd1674, 13'sd535},
		'{13'sd1449, 13'sd2281, 13'sd1705, -13'sd374},
		'{13'sd1449, 13'sd2066, 13'sd1715, 13'sd758},
		'{13'sd1459, 13'sd1859, 13'sd1797, 13'sd225},
		'{13'sd1544, 13'sd1754, 13'sd1444, -13'sd161},
		'{13'sd1656, 13'sd1516, 13'sd1423, 13'sd136},
		'{13'sd1682, 13'sd2294, 13'sd1428, -13'sd561},
		'{13'sd1718, 13'sd2117, 13'sd1400, -13'sd911},
		'{13'sd1590, 13'sd2358, 13'sd1477, 13'sd69},
		'{13'sd1759, 13'sd2120, 13'sd1544, -13'sd881},
		'{13'sd1764, 13'sd2289, 13'sd1731, -13'sd123},
		'{13'sd1720, 13'sd2335, 13'sd1641, -13'sd847},
		'{13'sd1718, 13'sd2468, 13'sd1664, -13'sd666},
		'{13'sd1636, 13'sd2542, 13'sd1728, -13'sd274},
		'{13'sd1759, 13'sd2575, 13'sd1667, -13'sd361},
		'{13'sd1659, 13'sd2604, 13'sd1815, 13'sd169},
		'{13'sd1741, 13'sd2650, 13'sd1754, -13'sd64}
	};

endpackage

[src/sae_front.sv]
// Front end: takes input words, keeps the three-position window and residue count,
// and turns each word into a job (valid flag, index, difference vectors). Uses sae_pkg.
module sae_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [71:0]               s_tdata,   // pos_x, pos_y, pos_z
	input  logic [1:0]                s_tuser,   // present, chain_start
	input  sae_pkg::sae_qstat_t       qst,
	output logic                      push,
	output sae_pkg::sae_job_t         job
);
	import sae_pkg::*;

	logic [2:0][2:0][COORD_W-1:0] win_q;
	logic [2:0]                   pres_q;
	logic [IDX_W-1:0]             cnt_q;
	logic [2:0][COORD_W-1:0]      cur;
	logic [2:0]                   pres_eff;
	logic [IDX_W-1:0]             cnt_eff;
	logic                         present;
	logic                         chain;

	assign s_tready = !qst.full;
	assign push     = s_tvalid && s_tready;
	assign present  = s_tuser[0];
	assign chain    = s_tuser[1];
	assign cur[0]   = s_tdata[COORD_W-1:0];
	assign cur[1]   = s_tdata[2*COORD_W-1:COORD_W];
	assign cur[2]   = s_tdata[3*COORD_W-1:2*COORD_W];
	assign pres_eff = chain ? 3'b000 : pres_q;
	assign cnt_eff  = chain ? '0 : cnt_q;

	always_comb begin
		job.ok  = (pres_eff == 3'b111) && present;
		job.idx = job.ok ? cnt_eff - IDX_W'(2) : '0;
		for (int k = 0; k < 3; k++) begin
			job.u[k]  = {win_q[1][k][COORD_W-1], win_q[1][k]} - {win_q[0][k][COORD_W-1], win_q[0][k]};
			job.v[k]  = {win_q[2][k][COORD_W-1], win_q[2][k]} - {win_q[0][k][COORD_W-1], win_q[0][k]};
			job.w[k]  = {cur[k][COORD_W-1], cur[k]} - {win_q[0][k][COORD_W-1], win_q[0][k]};
			job.bd[k] = {cur[k][COORD_W-1], cur[k]} - {win_q[1][k][COORD_W-1], win_q[1][k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pres_q <= '0;
			cnt_q  <= '0;
		end else if (push) begin
			pres_q <= {present, pres_eff[2:1]};
			cnt_q  <= (cnt_eff < MAX_COUNT) ? cnt_eff + IDX_W'(1) : cnt_eff;
		end
	end

	// window positions are payload: only read once the present bits say so
	always_ff @(posedge clk) begin
		if (push) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= cur;
		end
	end

endmodule

[src/sae_queue.sv]
// Two-entry job queue between front and back end.
// Uses sae_pkg for the job and status types.
module sae_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  sae_pkg::sae_job_t     din,
	input  logic                  pop,
	output sae_pkg::sae_job_t     dout,
	output sae_pkg::sae_qstat_t   qst
);
	import sae_pkg::*;

	sae_job_t   mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign dout      = mem_q[rp_q];
	assign qst.full  = (cnt_q == 2'd2);
	assign qst.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

endmodule

[src/sae_back.sv]
// Back end: runs one job at a time through a shared multiply unit, a bit-pair square
// root, a restoring divider and a pipelined prototype search. Uses sae_pkg.
module sae_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sae_pkg::sae_qstat_t   qst,
	input  sae_pkg::sae_job_t     head,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata,   // letter, residue_index, zero fill
	output logic [0:0]            m_tuser    // letter_valid
);
	import sae_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MAC   = 3'd1;
	localparam logic [2:0] ST_SQRT  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_SCORE = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	localparam logic [2:0] D_N0  = 3'd0;
	localparam logic [2:0] D_N1  = 3'd1;
	localparam logic [2:0] D_N2  = 3'd2;
	localparam logic [2:0] D_DOT = 3'd3;
	localparam logic [2:0] D_NN  = 3'd4;
	localparam logic [2:0] D_SV  = 3'd5;
	localparam logic [2:0] D_SW  = 3'd6;
	localparam logic [2:0] D_SB  = 3'd7;

	function automatic logic [MAG_W-1:0] ext_d(input logic [DIFF_W-1:0] x);
		return {{(MAG_W-DIFF_W){x[DIFF_W-1]}}, x};
	endfunction

	function automatic logic [MAG_W-1:0] ext_n(input logic [N_W-1:0] x);
		return {{(MAG_W-N_W){x[N_W-1]}}, x};
	endfunction

	logic [2:0]             st_q;
	sae_job_t               job_q;
	logic [4:0]             op_q;
	logic [2:0]             sub_q;
	logic [2*HALF_W-1:0]    pp_q;
	logic [1:0]             psh_q;
	logic [PROD_W-1:0]      prod_q;
	logic [N_W-1:0]         n0_q, n1_q, n2_q;
	logic [DOT_W-1:0]       dot_q;
	logic [NN_W-1:0]        nn_q;
	logic [SS_W-1:0]        sv_q, sw_q, sb_q;
	logic [RAD_W-1:0]       rad_q;
	logic [REM_W-1:0]       rem_q;
	logic [ROOT_W-1:0]      root_q;
	logic [1:0]             sqi_q;
	logic [6:0]             it_q;
	logic [ROOT_W-1:0]      nrm_q;
	logic [DESC_W-1:0]      d0_q, d1_q, d2_q;
	logic [D4_W-1:0]        d3_q;
	logic [DOT_W-1:0]       dm_q;
	logic [DREM_W-1:0]      drem_q;
	logic [Q_W-1:0]         qt_q;
	logic                   ovf_q;
	logic                   neg4_q;
	logic [4:0]             sj_q;
	logic [1:0]             sk_q;
	logic                   iss_q;
	logic                   v_s1;
	logic [4:0]             j_s1;
	logic [1:0]             k_s1;
	logic [SC_W-1:0]        sq_s1;
	logic [SC_W-1:0]        acc_q;
	logic [SC_W-1:0]        best_q;
	logic [LET_W-1:0]       let_q;
	logic [23:0]            tdata_q;
	logic                   tuser_q;
	logic                   tvalid_q;

	// multiply-accumulate operand selection
	logic [MAG_W-1:0]       op_a, op_b, mag_a, mag_b;
	logic [2:0]             op_dst;
	logic                   op_neg, neg_eff;
	logic [HALF_W-1:0]      half_a, half_b;
	logic [PROD_W-1:0]      pp_sh;
	logic [ACC_W-1:0]       acc_in, sprod, acc_out;
	logic                   mac_last;

	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_dst = D_N0;
		op_neg = 1'b0;
		case (op_q)
			5'd0: begin op_a = ext_d(job_q.u[1]); op_b = ext_d(job_q.v[2]); op_dst = D_N0; end
			5'd1: begin
				op_a = ext_d(job_q.u[2]); op_b = ext_d(job_q.v[1]); op_dst = D_N0; op_neg = 1'b1;
			end
			5'd2: begin op_a = ext_d(job_q.u[2]); op_b = ext_d(job_q.v[0]); op_dst = D_N1; end
			5'd3: begin
				op_a = ext_d(job_q.u[0]); op_b = ext_d(job_q.v[2]); op_dst = D_N1; op_neg = 1'b1;
			end
			5'd4: begin op_a = ext_d(job_q.u[0]); op_b = ext_d(job_q.v[1]); op_dst = D_N2; end
			5'd5: begin
				op_a = ext_d(job_q.u[1]); op_b = ext_d(job_q.v[0]); op_dst = D_N2; op_neg = 1'b1;
			end
			5'd6:  begin op_a = ext_n(n0_q); op_b = ext_d(job_q.w[0]); op_dst = D_DOT; end
			5'd7:  begin op_a = ext_n(n1_q); op_b = ext_d(job_q.w[1]); op_dst = D_DOT; end
			5'd8:  begin op_a = ext_n(n2_q); op_b = ext_d(job_q.w[2]); op_dst = D_DOT; end
			5'd9:  begin op_a = ext_n(n0_q); op_b = ext_n(n0_q); op_dst = D_NN; end
			5'd10: begin op_a = ext_n(n1_q); op_b = ext_n(n1_q); op_dst = D_NN; end
			5'd11: begin op_a = ext_n(n2_q); op_b = ext_n(n2_q); op_dst = D_NN; end
			5'd12: begin op_a = ext_d(job_q.v[0]); op_b = ext_d(job_q.v[0]); op_dst = D_SV; end
			5'd13: begin op_a = ext_d(job_q.v[1]); op_b = ext_d(job_q.v[1]); op_dst = D_SV; end
			5'd14: begin op_a = ext_d(job_q.v[2]); op_b = ext_d(job_q.v[2]); op_dst = D_SV; end
			5'd15: begin op_a = ext_d(job_q.w[0]); op_b = ext_d(job_q.w[0]); op_dst = D_SW; end
			5'd16: begin op_a = ext_d(job_q.w[1]); op_b = ext_d(job_q.w[1]); op_dst = D_SW; end
			5'd17: begin op_a = ext_d(job_q.w[2]); op_b = ext_d(job_q.w[2]); op_dst = D_SW; end
			5'd18: begin op_a = ext_d(job_q.bd[0]); op_b = ext_d(job_q.bd[0]); op_dst = D_SB; end
			5'd19: begin op_a = ext_d(job_q.bd[1]); op_b = ext_d(job_q.bd[1]); op_dst = D_SB; end
			5'd20: begin op_a = ext_d(job_q.bd[2]); op_b = ext_d(job_q.bd[2]); op_dst = D_SB; end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	assign mag_a    = op_a[MAG_W-1] ? -op_a : op_a;
	assign mag_b    = op_b[MAG_W-1] ? -op_b : op_b;
	assign neg_eff  = op_neg ^ op_a[MAG_W-1] ^ op_b[MAG_W-1];
	assign half_a   = sub_q[1] ? mag_a[MAG_W-1:HALF_W] : mag_a[HALF_W-1:0];
	assign half_b   = sub_q[0] ? mag_b[MAG_W-1:HALF_W] : mag_b[HALF_W-1:0];
	assign mac_last = (op_q == 5'(NUM_OPS - 1));

	always_comb begin
		case (psh_q)
			2'd0:    pp_sh = {{(PROD_W-2*HALF_W){1'b0}}, pp_q};
			2'd1:    pp_sh = {{(PROD_W-2*HALF_W){1'b0}}, pp_q} << HALF_W;
			2'd2:    pp_sh = {{(PROD_W-2*HALF_W){1'b0}}, pp_q} << (2 * HALF_W);
			default: pp_sh = '0;
		endcase
	end

	always_comb begin
		case (op_dst)
			D_N0:    acc_in = {{(ACC_W-N_W){n0_q[N_W-1]}}, n0_q};
			D_N1:    acc_in = {{(ACC_W-N_W){n1_q[N_W-1]}}, n1_q};
			D_N2:    acc_in = {{(ACC_W-N_W){n2_q[N_W-1]}}, n2_q};
			D_DOT:   acc_in = {{(ACC_W-DOT_W){dot_q[DOT_W-1]}}, dot_q};
			D_NN:    acc_in = {{(ACC_W-NN_W){1'b0}}, nn_q};
			D_SV:    acc_in = {{(ACC_W-SS_W){1'b0}}, sv_q};
			D_SW:    acc_in = {{(ACC_W-SS_W){1'b0}}, sw_q};
			D_SB:    acc_in = {{(ACC_W-SS_W){1'b0}}, sb_q};
			default: acc_in = '0;
		endcase
		sprod   = neg_eff ? -{2'b00, prod_q} : {2'b00, prod_q};
		acc_out = acc_in + sprod;
	end

	// square root step: two radicand bits per cycle
	logic [REM_W-1:0]  rem_sh, trial;
	logic              sq_ge;
	logic [ROOT_W-1:0] root_nx;

	assign rem_sh  = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial   = {{(REM_W-ROOT_W-2){1'b0}}, root_q, 2'b01};
	assign sq_ge   = (rem_sh >= trial);
	assign root_nx = {root_q[ROOT_W-2:0], sq_ge};

	// divider step: one quotient bit per cycle
	logic [DREM_W-1:0] drem_sh, nrm_ext;
	logic              dv_ge;
	logic [Q_W-1:0]    q_fin;

	assign drem_sh = {drem_q[DREM_W-2:0], dm_q[DOT_W-1]};
	assign nrm_ext = {1'b0, nrm_q};
	assign dv_ge   = (drem_sh >= nrm_ext);
	assign q_fin   = (ovf_q || qt_q[Q_W-1]) ? '1 : {qt_q[Q_W-2:0], dv_ge};

	// prototype search
	logic signed [E_W-1:0]     dsel, pext, e_val;
	logic signed [2*E_W-1:0]   e_sq;
	logic [SC_W-1:0]           tot;
	logic                      take_best;
	logic                      score_done;
	logic                      out_load;

	always_comb begin
		case (sk_q)
			2'd0:    dsel = {{(E_W-DESC_W){1'b0}}, d0_q};
			2'd1:    dsel = {{(E_W-DESC_W){1'b0}}, d1_q};
			2'd2:    dsel = {{(E_W-DESC_W){1'b0}}, d2_q};
			default: dsel = {{(E_W-D4_W){d3_q[D4_W-1]}}, d3_q};
		endcase
	end

	assign pext       = {{(E_W-PRO_W){PROTO[sj_q][sk_q][PRO_W-1]}}, PROTO[sj_q][sk_q]};
	assign e_val      = dsel - pext;
	assign e_sq       = e_val * e_val;
	assign tot        = ((k_s1 == 2'd0) ? '0 : acc_q) + sq_s1;
	assign take_best  = (j_s1 == 5'd0) || (tot < best_q);
	assign score_done = v_s1 && (k_s1 == 2'd3) && (j_s1 == 5'(NUM_LET - 1));
	assign out_load   = (st_q == ST_OUT) && (!tvalid_q || m_tready);

	assign pop      = (st_q == ST_IDLE) && !qst.empty;
	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			iss_q    <= 1'b0;
			v_s1     <= 1'b0;
			tvalid_q <= 1'b0;
		end else begin
			if (out_load) tvalid_q <= 1'b1;
			else if (m_tready) tvalid_q <= 1'b0;
			v_s1 <= iss_q;
			case (st_q)
				ST_IDLE: begin
					if (pop) st_q <= head.ok ? ST_MAC : ST_OUT;
				end
				ST_MAC: begin
					if (sub_q == 3'd5 && mac_last) st_q <= (nn_q == '0) ? ST_OUT : ST_SQRT;
				end
				ST_SQRT: begin
					if (it_q == 7'(SQ_ITERS - 1) && sqi_q == 2'd3) st_q <= ST_DIV;
				end
				ST_DIV: begin
					if (it_q == 7'(DOT_W - 1)) begin
						st_q  <= ST_SCORE;
						iss_q <= 1'b1;
					end
				end
				ST_SCORE: begin
					if (iss_q && sk_q == 2'd3 && sj_q == 5'(NUM_LET - 1)) iss_q <= 1'b0;
					if (score_done) st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		j_s1  <= sj_q;
		k_s1  <= sk_q;
		sq_s1 <= e_sq[SC_W-1:0];
		case (st_q)
			ST_IDLE: begin
				job_q  <= head;
				op_q   <= '0;
				sub_q  <= '0;
				n0_q   <= '0;
				n1_q   <= '0;
				n2_q   <= '0;
				dot_q  <= '0;
				nn_q   <= '0;
				sv_q   <= '0;
				sw_q   <= '0;
				sb_q   <= '0;
				let_q  <= '0;
			end
			ST_MAC: begin
				if (sub_q <= 3'd3) begin
					pp_q  <= half_a * half_b;
					psh_q <= {1'b0, sub_q[1]} + {1'b0, sub_q[0]};
				end
				if (sub_q == 3'd0) prod_q <= '0;
				else if (sub_q <= 3'd4) prod_q <= prod_q + pp_sh;
				if (sub_q == 3'd5) begin
					case (op_dst)
						D_N0:    n0_q  <= acc_out[N_W-1:0];
						D_N1:    n1_q  <= acc_out[N_W-1:0];
						D_N2:    n2_q  <= acc_out[N_W-1:0];
						D_DOT:   dot_q <= acc_out[DOT_W-1:0];
						D_NN:    nn_q  <= acc_out[NN_W-1:0];
						D_SV:    sv_q  <= acc_out[SS_W-1:0];
						D_SW:    sw_q  <= acc_out[SS_W-1:0];
						D_SB:    sb_q  <= acc_out[SS_W-1:0];
						default: n0_q  <= n0_q;
					endcase
					sub_q <= '0;
					op_q  <= op_q + 5'd1;
					// the normal's length goes through the root unit first
					rad_q  <= {{(RAD_W-NN_W){1'b0}}, nn_q};
					rem_q  <= '0;
					root_q <= '0;
					sqi_q  <= '0;
					it_q   <= '0;
				end else begin
					sub_q <= sub_q + 3'd1;
				end
			end
			ST_SQRT: begin
				if (it_q == 7'(SQ_ITERS - 1)) begin
					case (sqi_q)
						2'd0:    nrm_q <= root_nx;
						2'd1:    d0_q  <= root_nx[DESC_W-1:0];
						2'd2:    d1_q  <= root_nx[DESC_W-1:0];
						default: d2_q  <= root_nx[DESC_W-1:0];
					endcase
					case (sqi_q)
						2'd0:    rad_q <= {{(RAD_W-SS_W){1'b0}}, sv_q};
						2'd1:    rad_q <= {{(RAD_W-SS_W){1'b0}}, sw_q};
						default: rad_q <= {{(RAD_W-SS_W){1'b0}}, sb_q};
					endcase
					sqi_q  <= sqi_q + 2'd1;
					rem_q  <= '0;
					root_q <= '0;
					it_q   <= '0;
					neg4_q <= dot_q[DOT_W-1];
					dm_q   <= dot_q[DOT_W-1] ? -dot_q : dot_q;
					drem_q <= '0;
					qt_q   <= '0;
					ovf_q  <= 1'b0;
				end else begin
					rad_q  <= rad_q << 2;
					rem_q  <= sq_ge ? rem_sh - trial : rem_sh;
					root_q <= root_nx;
					it_q   <= it_q + 7'd1;
				end
			end
			ST_DIV: begin
				dm_q   <= dm_q << 1;
				drem_q <= dv_ge ? drem_sh - nrm_ext : drem_sh;
				qt_q   <= {qt_q[Q_W-2:0], dv_ge};
				ovf_q  <= ovf_q | qt_q[Q_W-1];
				it_q   <= it_q + 7'd1;
				if (it_q == 7'(DOT_W - 1)) begin
					// saturate the quotient, then apply the sign of the dot product
					d3_q <= neg4_q ? -{1'b0, q_fin} : {1'b0, q_fin};
					sj_q <= '0;
					sk_q <= '0;
				end
			end
			ST_SCORE: begin
				if (iss_q) begin
					sk_q <= sk_q + 2'd1;
					if (sk_q == 2'd3) sj_q <= sj_q + 5'd1;
				end
				if (v_s1) begin
					acc_q <= tot;
					if (k_s1 == 2'd3 && take_best) begin
						best_q <= tot;
						let_q  <= j_s1;
					end
				end
			end
			ST_OUT: begin
				if (out_load) begin
					tdata_q <= {3'b000, job_q.idx, let_q};
					tuser_q <= job_q.ok;
				end
			end
			default: op_q <= op_q;
		endcase
	end

endmodule

[src/structural_alphabet_encoder.sv]
// Structural alphabet encoder top level: front end, job queue and back end.
// Uses sae_pkg, sae_front, sae_queue and sae_back.
//
// Usage:
//   Input stream (s_*): one C-alpha position per word, x/y/z in s_tdata, present and
//   chain_start in s_tuser. Output stream (m_*): exactly one word per input word, in
//   order, carrying letter and residue_index in m_tdata and letter_valid in m_tuser.
//   A word that gives no letter goes from the queue straight to the output step.
//   A degenerate plane (zero normal) leaves after the multiply-accumulate steps; a
//   full letter takes 21 multiply-accumulate steps on the shared 26x26
//   multiplier, four 52-step square roots, a 78-step divide and a 108-entry
//   pipelined prototype search, all on one back-end sequencer.
//   Throughput: one item at a time in the back end; the front end and a two-entry
//   queue keep taking input words while it works, so s_tready drops only when the
//   queue is full.
//   Reset (arst_n low) clears the window present bits, residue count, queue and
//   output valid flag. When the receiver holds m_tready low, the result word holds,
//   the back end waits in its output step and the queue fills behind it.
module structural_alphabet_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // pos_x [23:0], pos_y [47:24], pos_z [71:48]
	input  logic [1:0]  s_tuser,   // present [0], chain_start [1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // letter [4:0], residue_index [20:5], zero [23:21]
	output logic [0:0]  m_tuser    // letter_valid [0]
);
	import sae_pkg::*;

	sae_job_t   fr_job;
	sae_job_t   q_head;
	sae_qstat_t qst;
	logic       push;
	logic       pop;

	sae_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.qst      (qst),
		.push     (push),
		.job      (fr_job)
	);

	sae_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (fr_job),
		.pop    (pop),
		.dout   (q_head),
		.qst    (qst)
	);

	sae_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qst      (qst),
		.head     (q_head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

[src/sae_checker.sv]
// Port-level checks for the structural alphabet encoder, bound to the top level.
// Depends only on the top level's ports.
module sae_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [71:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// hold a stalled result word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// drop letter and index when no letter was formed
	a_nolet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 24'd0)
		else $error("word without letter carries nonzero data");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[4:0] <= 5'd26 && m_tdata[23:21] == 3'd0)
		else $error("letter out of range or fill bits set");

endmodule

bind structural_alphabet_encoder sae_checker u_sae_checker (.*);

[sim/structural_alphabet_encoder_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for structural_alphabet_encoder: streams C-alpha positions in,
// predicts each output word with a local fixed-point classifier and compares in order.
// Depends on the RTL top level only; no files or arguments.
module structural_alphabet_encoder_test;

	localparam longint DIFF_LIM  = 33554431;
	localparam longint DESC_LIM  = 268435455;
	localparam int     IDLE_LIM  = 20000;
	localparam int     COORD_MAX = 8388607;
	localparam int     COORD_MIN = -8388608;

	typedef struct {
		int x, y, z;
		bit present, chain_start, drain;
	} residue_t;

	typedef struct {
		logic [4:0]  letter;
		logic        valid;
		logic [15:0] index;
	} letter_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;   // pos_x [23:0], pos_y [47:24], pos_z [71:48]
	logic [1:0]  s_tuser = '0;   // present [0], chain_start [1]
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [23:0] m_tdata;        // letter [4:0], residue_index [20:5]
	logic [0:0]  m_tuser;        // letter_valid [0]

	structural_alphabet_encoder uut (.*);

	always #5 clk = ~clk;

	residue_t pending[$];
	letter_t  letters_due[$];
	int       errors = 0;
	int       words_out = 0;

	// predictor state
	longint   win[3][3];
	bit [2:0] win_present = '0;
	bit [15:0] chain_idx = '0;

	longint proto[27][4] = '{
		'{1380, 1303, 1377, 748},  '{1390, 1303, 1388, 753},  '{1385, 1339, 1436, 732},
		'{1439, 1344, 1388, 735},  '{1431, 1405, 1480, 660},  '{1382, 1428, 1388, 868},
		'{1480, 1454, 1554, 374},  '{1421, 1981, 1434, -847}, '{1434, 1718, 1408, 945},
		'{1457, 2071, 1452, 791},  '{1449, 2291, 1674, 535},  '{1449, 2281, 1705, -374},
		'{1449, 2066, 1715, 758},  '{1459, 1859, 1797, 225},  '{1544, 1754, 1444, -161},
		'{1656, 1516, 1423, 136},  '{1682, 2294, 1428, -561}, '{1718, 2117, 1400, -911},
		'{1590, 2358, 1477, 69},   '{1759, 2120, 1544, -881}, '{1764, 2289, 1731, -123},
		'{1720, 2335, 1641, -847}, '{1718, 2468, 1664, -666}, '{1636, 2542, 1728, -274},
		'{1759, 2575, 1667, -361}, '{1659, 2604, 1815, 169},  '{1741, 2650, 1754, -64}
	};

	function automatic logic [63:0] root_floor(logic [127:0] v);
		logic [63:0] r, c;
		r = '0;
		for (int k = 63; k >= 0; k--) begin
			c = r | (64'd1 << k);
			if ({64'd0, c} * {64'd0, c} <= v)
				r = c;
		end
		return r;
	endfunction

	function automatic longint clip_diff(longint p, longint q);
		longint d;
		d = p - q;
		if (d > DIFF_LIM) d = DIFF_LIM;
		if (d < -DIFF_LIM) d = -DIFF_LIM;
		return d;
	endfunction

	function automatic longint length3(longint v[3]);
		logic [127:0] s;
		s = '0;
		for (int k = 0; k < 3; k++)
			s += 128'(v[k] * v[k]);
		return longint'(root_floor(s));
	endfunction

	function automatic logic [4:0] nearest_letter(longint a[3], longint b[3], longint c[3],
			longint d[3]);
		longint u[3], v[3], w[3], bd[3], n[3], desc[4], e;
		logic signed [127:0] dot, nn, ww, dmag;
		logic [127:0] n2, quo;
		longint unsigned score, best;
		logic [4:0] pick;
		for (int k = 0; k < 3; k++) begin
			u[k] = clip_diff(b[k], a[k]);
			v[k] = clip_diff(c[k], a[k]);
			w[k] = clip_diff(d[k], a[k]);
			bd[k] = clip_diff(d[k], b[k]);
		end
		n[0] = u[1] * v[2] - u[2] * v[1];
		n[1] = u[2] * v[0] - u[0] * v[2];
		n[2] = u[0] * v[1] - u[1] * v[0];
		dot = '0;
		n2 = '0;
		for (int k = 0; k < 3; k++) begin
			nn = n[k];
			ww = w[k];
			dot += nn * ww;
			n2 += nn * nn;
		end
		if (n2 == 0)
			return 5'd0;
		dmag = (dot < 0) ? -dot : dot;
		quo = dmag / {64'd0, root_floor(n2)};
		if (quo > DESC_LIM) quo = DESC_LIM;
		desc[0] = length3(v);
		desc[1] = length3(w);
		desc[2] = length3(bd);
		desc[3] = (dot < 0) ? -longint'(quo) : longint'(quo);
		best = '1;
		pick = '0;
		for (int j = 0; j < 27; j++) begin
			score = 0;
			for (int k = 0; k < 4; k++) begin
				e = desc[k] - proto[j][k];
				score += e * e;
			end
			if (score < best) begin
				best = score;
				pick = 5'(j);
			end
		end
		return pick;
	endfunction

	task automatic predict_letter(residue_t r);
		longint cur[3];
		letter_t o;
		bit [15:0] idx;
		// only the low 24 bits travel on the bus
		cur = '{longint'($signed(r.x[23:0])), longint'($signed(r.y[23:0])),
			longint'($signed(r.z[23:0]))};
		if (r.chain_start) begin
			win_present = '0;
			chain_idx = '0;
		end
		idx = chain_idx;
		o.valid = (win_present == 3'b111) && r.present;
		o.letter = o.valid ? nearest_letter(win[0], win[1], win[2], cur) : 5'd0;
		o.index = o.valid ? idx - 16'd2 : 16'd0;
		letters_due = {letters_due, o};
		win[0] = win[1];
		win[1] = win[2];
		win[2] = cur;
		win_present = {r.present, win_present[2:1]};
		if (chain_idx != 16'hFFFF)
			chain_idx++;
	endtask

	// sender
	int       send_gap = 0;
	bit       send_burst = 0;
	residue_t on_bus;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_letter(on_bus);
				if ($urandom_range(0, 199) == 0)
					send_burst = !send_burst;
				if (send_burst)
					send_gap = 0;
				else if ($urandom_range(0, 99) < 65)
					send_gap = 0;
				else if ($urandom_range(0, 99) < 90)
					send_gap = $urandom_range(1, 3);
				else
					send_gap = $urandom_range(10, 60);
			end
			if (!(s_tvalid && !s_tready)) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending.size() > 0 &&
						!(pending[0].drain && letters_due.size() > 0)) begin
					on_bus = pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {on_bus.z[23:0], on_bus.y[23:0], on_bus.x[23:0]};
					s_tuser <= {on_bus.chain_start, on_bus.present};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver
	int  hold_off = 0;
	bit  long_hold_done = 0;
	letter_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				words_out++;
				if (letters_due.size() == 0) begin
					$error("unexpected output word %h", m_tdata);
					errors++;
				end else begin
					want = letters_due.pop_front();
					if (m_tdata[4:0] !== want.letter) begin
						$error("letter: expected %0d, got %0d", want.letter, m_tdata[4:0]);
						errors++;
					end
					if (m_tdata[20:5] !== want.index) begin
						$error("residue_index: expected %0d, got %0d", want.index,
							m_tdata[20:5]);
						errors++;
					end
					if (m_tuser[0] !== want.valid) begin
						$error("letter_valid: expected %0d, got %0d", want.valid, m_tuser[0]);
						errors++;
					end
				end
			end
			if (!long_hold_done && words_out >= 150) begin
				long_hold_done = 1;
				hold_off = 2000;
			end else if (hold_off == 0 && $urandom_range(0, 99) < 3) begin
				hold_off = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
					: $urandom_range(1, 4);
			end
			if (hold_off > 0) begin
				hold_off--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog: stop when neither side moves a word for too long
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else if (arst_n && ++idle_cycles >= IDLE_LIM) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic add_residue(int x, int y, int z, bit present, bit chain_start,
			bit drain = 0);
		residue_t r;
		r = '{x, y, z, present, chain_start, drain};
		pending = {pending, r};
	endtask

	function automatic int clamp_coord(longint v);
		if (v > COORD_MAX) return COORD_MAX;
		if (v < COORD_MIN) return COORD_MIN;
		return int'(v);
	endfunction

	// backbone-like walk: steps of a few Angstrom, occasional gaps
	task automatic add_chain(int len, int absent_pct, int step, bit drain);
		longint p[3];
		for (int k = 0; k < 3; k++)
			p[k] = $signed($urandom_range(0, 2 * COORD_MAX)) - COORD_MAX;
		for (int i = 0; i < len; i++) begin
			for (int k = 0; k < 3; k++)
				p[k] = clamp_coord(p[k] + $signed($urandom_range(0, 2 * step)) - step);
			add_residue(int'(p[0]), int'(p[1]), int'(p[2]),
				$urandom_range(0, 99) >= absent_pct, i == 0, drain && i == 0);
		end
	endtask

	initial begin
		int n;
		win = '{default: 0};
		// extremes of every coordinate
		add_residue(COORD_MAX, COORD_MAX, COORD_MAX, 1, 1);
		add_residue(COORD_MIN, COORD_MIN, COORD_MIN, 1, 0);
		add_residue(COORD_MAX, COORD_MIN, COORD_MAX, 1, 0);
		add_residue(COORD_MIN, COORD_MAX, COORD_MIN, 1, 0);
		add_residue(0, COORD_MAX, COORD_MIN, 1, 0);
		// zero normal: repeated point, then collinear points
		add_residue(1000, 1000, 1000, 1, 1);
		add_residue(1000, 1000, 1000, 1, 0);
		add_residue(1000, 1000, 1000, 1, 0);
		add_residue(1000, 1000, 1000, 1, 0);
		add_residue(0, 0, 0, 1, 1);
		add_residue(900, 900, 900, 1, 0);
		add_residue(1800, 1800, 1800, 1, 0);
		add_residue(0, 1000, 0, 1, 0);
		// absent residue breaks the window
		add_residue(0, 0, 0, 1, 1);
		add_residue(973, 0, 0, 1, 0);
		add_residue(973, 973, 0, 0, 0);
		add_residue(973, 973, 973, 1, 0);
		// chain restart right after a full window
		add_residue(0, 0, 0, 1, 1, 1);
		add_residue(973, 0, 0, 1, 0);
		add_residue(973, 973, 0, 1, 0);
		add_residue(0, 973, 500, 1, 0);
		add_residue(0, 0, 973, 1, 1);
		// absent chain start, then a short present run
		add_residue(0, 0, 0, 0, 1);
		for (int i = 0; i < 7; i++)
			add_residue(i * 700, (i % 2) * 900, (i % 3) * 600, 1, 0);
		// random part: mostly well-formed chains, some noise
		n = 0;
		while (n < 1620) begin
			if ($urandom_range(0, 99) < 80) begin
				int len;
				len = $urandom_range(4, 40);
				add_chain(len, $urandom_range(0, 8),
					($urandom_range(0, 9) == 0) ? 2000000 : 700,
					$urandom_range(0, 99) < 4);
				n += len;
			end else begin
				int len;
				len = $urandom_range(1, 5);
				for (int i = 0; i < len; i++)
					add_residue(int'($urandom), int'($urandom), int'($urandom),
						1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
				n += len;
			end
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk);
		while (pending.size() > 0 || s_tvalid || letters_due.size() > 0);
		repeat (50) @(posedge clk);
		if (errors == 0 && letters_due.size() == 0 && !m_tvalid)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
